// ----- rtl/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and default sizes for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEQ_DEPTH      = 32;
    localparam int DEQ_DATA_WIDTH = 32;

    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 6;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

// ----- rtl/double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed words held in a ring buffer memory.
// ----------------------------------------------------------------------------
// Each input word carries an operation (push front, push back, pop front,
// pop back) and a value; each gives exactly one result word with the popped
// value (zero unless a pop succeeded), a status (ok, empty, full) and the
// entry count after the operation. Entries live in a single-port-write,
// registered-read memory addressed through a head pointer and a count. An
// operation updates the pointers and writes the memory in the cycle it is
// accepted; a pop's data comes from the registered memory read, through a
// holding stage and then the output register. One operation is accepted
// per clock as long as results are taken; a result is valid on the master
// side once it has passed the holding stage and the output register.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH      = DEQ_DEPTH,
    parameter int DATA_WIDTH = DEQ_DATA_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] push_value
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] pop_value, [37:32] entry_count, zero above
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int EW = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [IW:0]   DEPTH_X  = (IW + 1)'(DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

    // entry memory
    logic signed [DATA_WIDTH-1:0] mem [DEPTH];
    logic signed [DATA_WIDTH-1:0] r_rd_data;

    logic [IW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;

    // holding stage: result waiting for read data
    logic          r_s1_valid;
    t_status       r_s1_status, n_s1_status;
    logic [CW-1:0] r_s1_count;
    logic          r_s1_pop, n_s1_pop;

    // output register
    logic                r_out_valid;
    t_status             r_out_status;
    logic [CW-1:0]       r_out_count;
    logic [VALUE_W-1:0]  r_out_value;

    logic          s_accept;
    logic          s1_adv;
    t_opcode       op;
    logic          mem_we, mem_re;
    logic [IW-1:0] mem_wa, mem_ra;
    logic [IW:0]   sum_hc;
    logic [IW:0]   sum_last;
    logic [IW-1:0] tail_idx;
    logic [IW-1:0] last_idx;
    logic [IW-1:0] head_dec;
    logic [IW-1:0] head_inc;
    logic [EW-1:0] pop_ext;
    logic [XW-1:0] cnt_ext;

    assign s1_adv        = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign op            = t_opcode'(s_axis_tuser);

    // ring index arithmetic, sums stay below twice the depth
    always_comb begin
        sum_hc   = {1'b0, r_head} + (IW + 1)'(r_count);
        sum_last = sum_hc - 1'b1;
        tail_idx = (sum_hc >= DEPTH_X) ? IW'(sum_hc - DEPTH_X) : sum_hc[IW-1:0];
        last_idx = (sum_last >= DEPTH_X) ? IW'(sum_last - DEPTH_X) : sum_last[IW-1:0];
        head_dec = (r_head == '0) ? LAST_IDX : r_head - 1'b1;
        head_inc = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    end

    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_s1_status = ST_OK;
        n_s1_pop    = 1'b0;
        mem_we      = 1'b0;
        mem_wa      = tail_idx;
        mem_re      = 1'b0;
        mem_ra      = r_head;
        if (s_accept) begin
            unique case (op)
                OP_PUSH_FRONT: begin
                    if (r_count >= FULL_CNT) begin
                        n_s1_status = ST_FULL;
                    end else begin
                        n_head  = head_dec;
                        n_count = r_count + 1'b1;
                        mem_we  = 1'b1;
                        mem_wa  = head_dec;
                    end
                end
                OP_PUSH_BACK: begin
                    if (r_count >= FULL_CNT) begin
                        n_s1_status = ST_FULL;
                    end else begin
                        n_count = r_count + 1'b1;
                        mem_we  = 1'b1;
                        mem_wa  = tail_idx;
                    end
                end
                OP_POP_FRONT: begin
                    if (r_count == '0) begin
                        n_s1_status = ST_EMPTY;
                    end else begin
                        n_head   = head_inc;
                        n_count  = r_count - 1'b1;
                        mem_re   = 1'b1;
                        mem_ra   = r_head;
                        n_s1_pop = 1'b1;
                    end
                end
                OP_POP_BACK: begin
                    if (r_count == '0) begin
                        n_s1_status = ST_EMPTY;
                    end else begin
                        n_count  = r_count - 1'b1;
                        mem_re   = 1'b1;
                        mem_ra   = last_idx;
                        n_s1_pop = 1'b1;
                    end
                end
                default: begin
                    n_s1_status = ST_OK;
                end
            endcase
        end
    end

    // memory: write at acceptance, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= DATA_WIDTH'(signed'(s_axis_tdata));
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            if (s_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: hold while stalled
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_status <= n_s1_status;
            r_s1_count  <= n_count;
            r_s1_pop    <= n_s1_pop;
        end
        if (s1_adv) begin
            r_out_status <= r_s1_status;
            r_out_count  <= r_s1_count;
            r_out_value  <= r_s1_pop ? pop_ext[VALUE_W-1:0] : '0;
        end
    end

    assign pop_ext = EW'(r_rd_data);
    assign cnt_ext = XW'(r_out_count);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, cnt_ext[COUNT_W-1:0], r_out_value};
    assign m_axis_tuser  = r_out_status;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count exceeds depth");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_status == ST_EMPTY) |-> (r_out_value == '0) && (r_out_count == '0))
        else $error("refused pop reports data or nonzero count");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_status == ST_FULL) |-> (r_out_count == FULL_CNT))
        else $error("refused push reports count below depth");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && ((op == OP_PUSH_FRONT) || (op == OP_PUSH_BACK)) && (r_count < FULL_CNT)
        |=> r_count == $past(r_count) + 1'b1)
        else $error("accepted push did not grow the count");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |=> r_s1_valid && $stable(r_s1_status) && $stable(r_s1_count))
        else $error("holding stage lost a word under stall");

endmodule
